/* hw/rtl/r565bw_pkg.sv */
// Package for the RGB888/RGBA8888 to RGB565 blit writer.
// Holds the word types, register map, widths, packing and clamping helpers; no dependencies.
package r565bw_pkg;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned ORG_W   = 10;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned PIX_W   = 16;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_BLIT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_BLIT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [2:0] REG_ROTATED       = 3'd6;
  localparam logic [2:0] REG_ALPHA_MODE    = 3'd7;

  localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd320;
  localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd240;

  localparam logic [7:0] RED_MASK = 8'hF8;
  localparam logic [7:0] GRN_MASK = 8'hFC;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  pixel_565;
    logic              last_of_blit;
  } pixel_out_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [10:0] v);
    logic [DIM_W-1:0] r;
    if (v == 11'd0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_screen(input logic [10:0] v);
    logic [DIM_W-1:0] r;
    if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] pack_565(input pixel_in_t p);
    logic [7:0] r;
    logic [7:0] g;
    r = p.red & RED_MASK;
    g = p.green & GRN_MASK;
    return {r[7:3], g[7:2], p.blue[7:3]};
  endfunction

endpackage

/* hw/rtl/rgb_to_rgb565_blit_writer_unit.sv */
// Top level of the RGB565 blit writer: APB register file, raster counters,
// input stage and framebuffer write register. Depends on r565bw_pkg.

// Takes one source pixel word per clock in raster order unless stalled, and
// gives at most one framebuffer write word (address, RGB565 data, last flag)
// per pixel via the input register, then the write register. The path from
// the input register to the write register holds the single row-times-width
// multiply and the on-screen checks. Transparent (alpha mode, alpha zero) and
// off-screen pixels make no write but still advance the counters. The user
// must write registers only while no pixel is in flight; it is not enforced.
module rgb_to_rgb565_blit_writer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  r565bw_pkg::pixel_in_t           in_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output r565bw_pkg::pixel_out_t          out_write_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [r565bw_pkg::PADDR_W-1:0]  paddr,
  input  logic [r565bw_pkg::PDATA_W-1:0]  pwdata,
  output logic [r565bw_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned CW = r565bw_pkg::CNT_W;
  localparam int unsigned DW = r565bw_pkg::DIM_W;

  // configuration
  logic [9:0]  origin_x_q, origin_y_q;
  logic [10:0] blit_width_q, blit_height_q, screen_width_q, screen_height_q;
  logic        rotated_q, alpha_mode_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      blit_width_q    <= 11'd1;
      blit_height_q   <= 11'd1;
      screen_width_q  <= r565bw_pkg::RST_SCREEN_WIDTH;
      screen_height_q <= r565bw_pkg::RST_SCREEN_HEIGHT;
      rotated_q       <= 1'b0;
      alpha_mode_q    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        r565bw_pkg::REG_ORIGIN_X:      origin_x_q      <= pwdata[9:0];
        r565bw_pkg::REG_ORIGIN_Y:      origin_y_q      <= pwdata[9:0];
        r565bw_pkg::REG_BLIT_WIDTH:    blit_width_q    <= pwdata[10:0];
        r565bw_pkg::REG_BLIT_HEIGHT:   blit_height_q   <= pwdata[10:0];
        r565bw_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[10:0];
        r565bw_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[10:0];
        r565bw_pkg::REG_ROTATED:       rotated_q       <= pwdata[0];
        r565bw_pkg::REG_ALPHA_MODE:    alpha_mode_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      r565bw_pkg::REG_ORIGIN_X:      prdata = 32'(origin_x_q);
      r565bw_pkg::REG_ORIGIN_Y:      prdata = 32'(origin_y_q);
      r565bw_pkg::REG_BLIT_WIDTH:    prdata = 32'(blit_width_q);
      r565bw_pkg::REG_BLIT_HEIGHT:   prdata = 32'(blit_height_q);
      r565bw_pkg::REG_SCREEN_WIDTH:  prdata = 32'(screen_width_q);
      r565bw_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_height_q);
      r565bw_pkg::REG_ROTATED:       prdata = 32'(rotated_q);
      r565bw_pkg::REG_ALPHA_MODE:    prdata = 32'(alpha_mode_q);
      default:                       prdata = '0;
    endcase
  end

  // handshake
  logic stg_valid_q, out_valid_q;
  logic stg_adv, in_acc;

  assign stg_adv    = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~stg_valid_q | stg_adv;
  assign in_acc     = in_valid_i & in_ready_o;

  // raster counters
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [DW-1:0] blit_w, blit_h;
  logic          col_end, row_end;

  assign blit_w  = r565bw_pkg::clamp_dim(blit_width_q);
  assign blit_h  = r565bw_pkg::clamp_dim(blit_height_q);
  assign col_end = ({1'b0, col_q} + DW'(1)) >= blit_w;
  assign row_end = ({1'b0, row_q} + DW'(1)) >= blit_h;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : row_q + CW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // input stage
  logic [CW-1:0]                 stg_row_q, stg_col_q;
  logic                          stg_last_q, stg_clear_q;
  logic [r565bw_pkg::PIX_W-1:0]  stg_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_row_q   <= row_q;
      stg_col_q   <= col_q;
      stg_last_q  <= col_end & row_end;
      stg_clear_q <= alpha_mode_q & (in_pixel_i.alpha == 8'd0);
      stg_pix_q   <= r565bw_pkg::pack_565(in_pixel_i);
    end
  end

  // placement and screen clipping
  logic [DW-1:0]   scr_w, scr_h;
  logic [10:0]     sum_x, sum_y, scr_row, scr_col;
  logic            col_ok, emit;
  logic [21:0]     row_off;
  logic [22:0]     addr_full;

  assign scr_w = r565bw_pkg::clamp_screen(screen_width_q);
  assign scr_h = r565bw_pkg::clamp_screen(screen_height_q);
  assign sum_x = {1'b0, origin_x_q} + 11'(stg_col_q);
  assign sum_y = {1'b0, origin_y_q} + 11'(stg_row_q);

  always_comb begin
    if (rotated_q) begin
      scr_row = sum_x;
      scr_col = 11'(scr_w) - 11'd1 - sum_y;
      col_ok  = sum_y < 11'(scr_w);
    end else begin
      scr_row = sum_y;
      scr_col = sum_x;
      col_ok  = sum_x < 11'(scr_w);
    end
  end

  assign emit      = col_ok & (scr_row < 11'(scr_h)) & ~stg_clear_q;
  assign row_off   = 22'(scr_row) * 22'(scr_w);
  assign addr_full = {1'b0, row_off} + 23'(scr_col);

  // write register
  r565bw_pkg::pixel_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_adv) begin
      out_valid_q <= stg_valid_q & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv) begin
      out_q.write_address <= addr_full[r565bw_pkg::ADDR_W-1:0];
      out_q.pixel_565     <= stg_pix_q;
      out_q.last_of_blit  <= stg_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_write_o = out_q;

endmodule

/* tb/tb_rgb_to_rgb565_blit_writer_unit.sv */
`timescale 1ns / 1ps
// Testbench for rgb_to_rgb565_blit_writer_unit: a directed table, then random register phases.
// Each framebuffer write word is checked against a built-in placement predictor or, for typed rows, the table's word.
// Depends on r565bw_pkg and the unit's RTL only.
module tb_rgb_to_rgb565_blit_writer_unit;
  import r565bw_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int SETTLE     = 6;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 1760;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] value;
    pixel_in_t   pix;
    bit          typed;
    bit          typed_emit;
    pixel_out_t  typed_word;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  pixel_in_t          in_pixel_i;
  logic               out_valid_o;
  logic               out_ready_i;
  pixel_out_t         out_write_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [ORG_W-1:0] org_x;
  logic [ORG_W-1:0] org_y;
  logic [10:0]      blit_w;
  logic [10:0]      blit_h;
  logic [10:0]      scr_w;
  logic [10:0]      scr_h;
  logic             rot;
  logic             alpha_en;
  int               src_row;
  int               src_col;

  pixel_out_t pending_writes[$];
  stim_row_t  dir_rows[$];
  pixel_out_t exp_word;
  pixel_out_t got_word;
  int         err_count;
  int         pix_sent;
  int         pix_dropped;
  int         writes_seen;
  int         reg_writes;
  int         idle_cycles;
  int         rdy_hold;
  bit         no_idle;

  rgb_to_rgb565_blit_writer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_pixel_i (in_pixel_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_write_o(out_write_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic logic [31:0] field_mask(logic [2:0] idx);
    case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y: return 32'h3FF;
      REG_ROTATED, REG_ALPHA_MODE: return 32'h1;
      default: return 32'h7FF;
    endcase
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_ORIGIN_X: org_x = v[9:0];
      REG_ORIGIN_Y: org_y = v[9:0];
      REG_BLIT_WIDTH: blit_w = v[10:0];
      REG_BLIT_HEIGHT: blit_h = v[10:0];
      REG_SCREEN_WIDTH: scr_w = v[10:0];
      REG_SCREEN_HEIGHT: scr_h = v[10:0];
      REG_ROTATED: rot = v[0];
      default: alpha_en = v[0];
    endcase
  endfunction

  function automatic int fit_dim(logic [10:0] v, bit zero_is_one);
    if (v == 11'd0 && zero_is_one) return 1;
    if (int'(v) > int'(MAX_DIM)) return int'(MAX_DIM);
    return int'(v);
  endfunction

  // Placement, drop rules and raster advance for one source pixel.
  function automatic bit place_pixel(input pixel_in_t p, output pixel_out_t w);
    int bw;
    int bh;
    int sw;
    int sh;
    int row;
    int col;
    bit col_end;
    bit row_end;
    bit emit;
    bw = fit_dim(blit_w, 1'b1);
    bh = fit_dim(blit_h, 1'b1);
    sw = fit_dim(scr_w, 1'b0);
    sh = fit_dim(scr_h, 1'b0);
    col_end = (src_col + 1) >= bw;
    row_end = (src_row + 1) >= bh;
    if (rot) begin
      row = int'(org_x) + src_col;
      col = sw - 1 - int'(org_y) - src_row;
    end else begin
      row = int'(org_y) + src_row;
      col = int'(org_x) + src_col;
    end
    emit = !(col < 0 || col >= sw || row >= sh) && !(alpha_en && p.alpha == 8'd0);
    if (col_end) begin
      src_col = 0;
      src_row = row_end ? 0 : src_row + 1;
    end else begin
      src_col = src_col + 1;
    end
    w.write_address = ADDR_W'(row * sw + col);
    w.pixel_565     = {p.red[7:3], p.green[7:2], p.blue[7:3]};
    w.last_of_blit  = col_end && row_end;
    return emit;
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] v);
    stim_row_t r;
    r.kind       = ROW_CFG;
    r.idx        = idx;
    r.value      = v;
    r.pix        = '0;
    r.typed      = 1'b0;
    r.typed_emit = 1'b0;
    r.typed_word = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_pix(pixel_in_t p, bit typed = 1'b0, bit emit = 1'b0,
                                  pixel_out_t w = '0);
    stim_row_t r;
    r.kind       = ROW_PIX;
    r.idx        = REG_ORIGIN_X;
    r.value      = '0;
    r.pix        = p;
    r.typed      = typed;
    r.typed_emit = emit;
    r.typed_word = w;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_extreme(int hi);
    case ($urandom_range(0, 2))
      0: return 32'd0;
      1: return 32'(hi);
      default: return 32'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    end
  endfunction

  task automatic send_pixel(pixel_in_t p, bit typed, bit typed_emit, pixel_out_t typed_word);
    int         gap;
    bit         emit;
    pixel_out_t w;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    emit = place_pixel(p, w);
    if (typed) begin
      emit = typed_emit;
      w    = typed_word;
    end
    if (emit) begin
      pending_writes.push_back(w);
    end else begin
      pix_dropped++;
    end
    pix_sent++;
    @(negedge clk_i);
  endtask

  // Pixels without a write may still be in the pipe once the queue is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, v);
    reg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (v & field_mask(idx))) begin
      err_count++;
      $display("%0t: readback of register %0d, expected %0h, got %0h",
               $time, idx, v & field_mask(idx), prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rdy_hold > 0) begin
      out_ready_i <= 1'b0;
      rdy_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      writes_seen++;
      rdy_hold = no_idle ? 0 : $urandom_range(0, 10);
      got_word = out_write_o;
      if (pending_writes.size() == 0) begin
        err_count++;
        $display("%0t: unexpected write word, expected none, got %h", $time, got_word);
      end else begin
        exp_word = pending_writes.pop_front();
        check_field("write_address", 32'(exp_word.write_address), 32'(got_word.write_address));
        check_field("pixel_565", 32'(exp_word.pixel_565), 32'(got_word.pixel_565));
        check_field("last_of_blit", 32'(exp_word.last_of_blit), 32'(got_word.last_of_blit));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d writes outstanding",
               $time, IDLE_LIMIT, pending_writes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] vals [8];
    pixel_in_t   p;
    int          dir_pix;
    int          sw;
    int          sh;
    int          n;
    logic        r_rot;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_pixel_i  = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    err_count   = 0;
    pix_sent    = 0;
    pix_dropped = 0;
    writes_seen = 0;
    reg_writes  = 0;
    idle_cycles = 0;
    rdy_hold    = 0;
    no_idle     = 1'b0;
    org_x       = '0;
    org_y       = '0;
    blit_w      = 11'd1;
    blit_h      = 11'd1;
    scr_w       = RST_SCREEN_WIDTH;
    scr_h       = RST_SCREEN_HEIGHT;
    rot         = 1'b0;
    alpha_en    = 1'b0;
    src_row     = 0;
    src_col     = 0;

    // reset state: 1x1 blit at the origin, every pixel is last
    add_pix({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1, 1, {20'd0, 16'hFFFF, 1'b1});
    add_pix({8'h00, 8'h00, 8'h00, 8'h00}, 1, 1, {20'd0, 16'h0000, 1'b1});
    add_pix({8'hF8, 8'h00, 8'h00, 8'h01}, 1, 1, {20'd0, 16'hF800, 1'b1});
    add_pix({8'h00, 8'hFC, 8'h00, 8'h80}, 1, 1, {20'd0, 16'h07E0, 1'b1});
    add_pix({8'h00, 8'h00, 8'hF8, 8'h7F}, 1, 1, {20'd0, 16'h001F, 1'b1});
    add_pix({8'h07, 8'h03, 8'h07, 8'hFE}, 1, 1, {20'd0, 16'h0000, 1'b1});
    // transparent final pixel, then opaque
    add_cfg(REG_ALPHA_MODE, 32'd1);
    add_pix({8'hAA, 8'h55, 8'hAA, 8'h00}, 1, 0, '0);
    add_pix({8'h55, 8'hAA, 8'h55, 8'h01}, 1, 1, {20'd0, 16'h554A, 1'b1});
    add_cfg(REG_ALPHA_MODE, 32'd0);
    add_cfg(REG_BLIT_WIDTH, 32'd0);
    add_pix({8'h12, 8'h34, 8'h56, 8'h78});
    add_pix({8'h9A, 8'hBC, 8'hDE, 8'hF0});
    // oversized width, right edge clipping
    add_cfg(REG_BLIT_WIDTH, 32'd2047);
    add_cfg(REG_BLIT_HEIGHT, 32'd2);
    add_cfg(REG_ORIGIN_X, 32'd318);
    add_pix({8'h80, 8'h40, 8'h20, 8'h10});
    add_pix({8'h01, 8'h02, 8'h04, 8'h08});
    add_pix({8'hFE, 8'hFD, 8'hFB, 8'hF7});
    // width shrunk below the column counter
    add_cfg(REG_BLIT_WIDTH, 32'd2);
    add_cfg(REG_ORIGIN_X, 32'd0);
    add_pix({8'hC3, 8'h3C, 8'h5A, 8'hA5});
    add_pix({8'h0F, 8'hF0, 8'h33, 8'hCC});
    add_pix({8'h7E, 8'h81, 8'h18, 8'hE7});
    add_cfg(REG_SCREEN_WIDTH, 32'd0);
    add_pix({8'h11, 8'h22, 8'h44, 8'h88});
    add_cfg(REG_SCREEN_WIDTH, 32'd1024);
    add_cfg(REG_SCREEN_HEIGHT, 32'd1024);
    add_cfg(REG_ORIGIN_X, 32'd1023);
    add_cfg(REG_ORIGIN_Y, 32'd1023);
    add_cfg(REG_BLIT_WIDTH, 32'd1);
    add_cfg(REG_BLIT_HEIGHT, 32'd1);
    add_pix({8'hFF, 8'h00, 8'hFF, 8'hFF});
    add_cfg(REG_ROTATED, 32'd1);
    add_cfg(REG_ORIGIN_X, 32'd0);
    add_cfg(REG_ORIGIN_Y, 32'd0);
    add_cfg(REG_BLIT_WIDTH, 32'd3);
    add_cfg(REG_BLIT_HEIGHT, 32'd2);
    add_cfg(REG_SCREEN_WIDTH, 32'd2047);
    add_cfg(REG_SCREEN_HEIGHT, 32'd2047);
    add_pix({8'h10, 8'h20, 8'h30, 8'h40});
    add_pix({8'h50, 8'h60, 8'h70, 8'h80});
    add_pix({8'h90, 8'hA0, 8'hB0, 8'hC0});
    add_pix({8'hD0, 8'hE0, 8'hF0, 8'h01});
    add_pix({8'h02, 8'h03, 8'h05, 8'h09});
    add_pix({8'hEF, 8'hDF, 8'hBF, 8'h7F});
    // rotated column goes negative on a single-pixel blit
    add_cfg(REG_ORIGIN_Y, 32'd1023);
    add_cfg(REG_SCREEN_WIDTH, 32'd16);
    add_cfg(REG_BLIT_WIDTH, 32'd1);
    add_cfg(REG_BLIT_HEIGHT, 32'd1);
    add_pix({8'h66, 8'h99, 8'h66, 8'h99});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    dir_pix = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        dir_pix++;
        send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].typed_emit,
                   dir_rows[i].typed_word);
      end
    end

    while (pix_sent < dir_pix + RAND_ITEMS) begin
      drain();
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        vals[REG_ORIGIN_X]      = pick_extreme(1023);
        vals[REG_ORIGIN_Y]      = pick_extreme(1023);
        vals[REG_BLIT_WIDTH]    = pick_extreme(2047);
        vals[REG_BLIT_HEIGHT]   = pick_extreme(2047);
        vals[REG_SCREEN_WIDTH]  = pick_extreme(2047);
        vals[REG_SCREEN_HEIGHT] = pick_extreme(2047);
        vals[REG_ROTATED]       = pick_extreme(1);
        vals[REG_ALPHA_MODE]    = pick_extreme(1);
      end else begin
        sw    = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(16, 1024);
        sh    = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(16, 1024);
        r_rot = 1'($urandom_range(0, 1));
        vals[REG_SCREEN_WIDTH]  = 32'(sw);
        vals[REG_SCREEN_HEIGHT] = 32'(sh);
        vals[REG_BLIT_WIDTH]    = 32'($urandom_range(1, 16));
        vals[REG_BLIT_HEIGHT]   = 32'($urandom_range(1, 16));
        vals[REG_ROTATED]       = 32'(r_rot);
        vals[REG_ALPHA_MODE]    = 32'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) begin
          vals[REG_ORIGIN_X] = 32'($urandom_range(0, 16));
          vals[REG_ORIGIN_Y] = 32'($urandom_range(0, 16));
        end else begin
          vals[REG_ORIGIN_X] = 32'($urandom_range(0, (r_rot ? sh : sw) - 1));
          vals[REG_ORIGIN_Y] = 32'($urandom_range(0, (r_rot ? sw : sh) - 1));
        end
      end
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 7) == 0) begin
            vals[k] = vals[k] | ($urandom & ~field_mask(3'(k)));
          end
          write_reg(3'(k), vals[k]);
        end
      end
      n = $urandom_range(20, 120);
      repeat (n) begin
        p.red   = 8'($urandom);
        p.green = 8'($urandom);
        p.blue  = 8'($urandom);
        p.alpha = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        send_pixel(p, 1'b0, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d pixels (%0d directed) with %0d register writes.", pix_sent, dir_pix,
             reg_writes);
    $display("Checked %0d framebuffer writes; %0d pixels dropped as off-screen or transparent.",
             writes_seen, pix_dropped);
    if (err_count == 0 && pending_writes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
